@@ hdl/sobel_3x3_gradient_defines.svh @@
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient assertion macros
// Shared assertion shorthands for the checker of the Sobel gradient block.
// ----------------------------------------------------------------------------
`ifndef SOBEL_3X3_GRADIENT_DEFINES_SVH
`define SOBEL_3X3_GRADIENT_DEFINES_SVH

// Assertion that is switched off while reset is asserted.
`define SOBEL_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is also checked while reset is asserted.
`define SOBEL_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/sobel_pkg.sv @@
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient package
// Types, register codes and constants shared by the Sobel gradient files.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // Default line store depth.
  localparam int DEF_MAX_WIDTH = 1024;

  // Largest frame height.
  localparam int HEIGHT_MAX = 4096;

  // Smallest frame width and height.
  localparam int SIZE_MIN = 3;

  // Register file layout.
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIRECTION    = 2'd2;

  // Register reset values.
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [12:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic        RST_DIRECTION    = 1'b1;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int GRAD_W = 11;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 10;

  // One result transaction.
  typedef struct packed {
    logic signed [GRAD_W-1:0] gradient;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } result_t;

  // Limit a value to the range lo..hi.
  function automatic int clamp_int(int v, int lo, int hi);
    int r;
    r = v;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

@@ hdl/sobel_3x3_gradient.sv @@
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient
// Streams 8-bit raster pixels through two line stores and a 3x3 window and
// returns the X or Y Sobel derivative of each pixel with its position.
// ----------------------------------------------------------------------------
// Usage: pixels enter in raster order on the in_valid_i/in_ready_o channel,
// one per transaction. Results leave on out_valid_o/out_ready_i, each with
// gradient, row, column and an end-of-frame flag. A result for pixel (r,c)
// is produced by the input at (r+1,c+1); the last column and the bottom row
// get zero results beside the input that completes them.
// Pipeline: an accepted input is registered in stage one and its results in
// the result buffer, from which they are offered. Throughput is one pixel per
// clock while the receiver is ready; an input that yields two or three
// results holds the input while they drain through the one result port. Both
// line stores share one 16-bit memory, read when a pixel is taken and written
// back as it leaves stage one. Reset clears the counters and loads width 640,
// height 480 and X direction. The line stores are not cleared: stale entries
// only ever feed border results, which are forced to zero. A stalled receiver
// holds the result buffer, which in turn holds the input channel; nothing is
// dropped. Writes to width or height restart the frame at row 0, column 0.
module sobel_3x3_gradient #(
  parameter int MAX_WIDTH = sobel_pkg::DEF_MAX_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Pixel input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [sobel_pkg::PIX_W-1:0]           pixel_i,
  // Result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [sobel_pkg::GRAD_W-1:0]   gradient_o,
  output logic [sobel_pkg::ROW_W-1:0]           out_row_o,
  output logic [sobel_pkg::COL_W-1:0]           out_col_o,
  output logic                                  frame_last_o,
  // Register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sobel_pkg::PADDR_W-1:0]         paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PW = sobel_pkg::PIX_W;
  localparam int GW = sobel_pkg::GRAD_W;
  localparam int RW = sobel_pkg::ROW_W;
  localparam int CW = sobel_pkg::COL_W;

  // Register file
  logic [10:0]   width_q;
  logic [12:0]   height_q;
  logic          dir_q;
  logic [AW-1:0] w_last_q;
  logic [RW-1:0] h_last_q;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;
  logic          restart;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];
  assign restart = cfg_wr & ((cfg_idx == sobel_pkg::REG_IMAGE_WIDTH) |
                             (cfg_idx == sobel_pkg::REG_IMAGE_HEIGHT));

  // Registers keep the raw value and the clamped last column and row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sobel_pkg::RST_IMAGE_WIDTH;
      height_q <= sobel_pkg::RST_IMAGE_HEIGHT;
      dir_q    <= sobel_pkg::RST_DIRECTION;
      w_last_q <= AW'(sobel_pkg::clamp_int(int'(sobel_pkg::RST_IMAGE_WIDTH),
                      sobel_pkg::SIZE_MIN, MAX_WIDTH) - 1);
      h_last_q <= RW'(sobel_pkg::clamp_int(int'(sobel_pkg::RST_IMAGE_HEIGHT),
                      sobel_pkg::SIZE_MIN, sobel_pkg::HEIGHT_MAX) - 1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sobel_pkg::REG_IMAGE_WIDTH: begin
          width_q  <= pwdata[10:0];
          w_last_q <= AW'(sobel_pkg::clamp_int(int'(pwdata[10:0]),
                          sobel_pkg::SIZE_MIN, MAX_WIDTH) - 1);
        end
        sobel_pkg::REG_IMAGE_HEIGHT: begin
          height_q <= pwdata[12:0];
          h_last_q <= RW'(sobel_pkg::clamp_int(int'(pwdata[12:0]),
                          sobel_pkg::SIZE_MIN, sobel_pkg::HEIGHT_MAX) - 1);
        end
        sobel_pkg::REG_DIRECTION: begin
          dir_q <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (cfg_idx)
      sobel_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_q);
      sobel_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_q);
      sobel_pkg::REG_DIRECTION:    prdata = 32'(dir_q);
      default:                     prdata = 32'd0;
    endcase
  end

  // Handshake signals between the stages.
  logic in_fire;
  logic s1_fire;
  logic load;
  logic out_fire;

  assign in_fire = in_valid_i & in_ready_o;

  // Position of the next input pixel.
  logic [AW-1:0] col_q;
  logic [RW-1:0] row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      if (col_q == w_last_q) begin
        col_q <= '0;
        row_q <= (row_q == h_last_q) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Stage one holds the accepted pixel while the line stores are read.
  logic          s1_valid_q;
  logic [PW-1:0] s1_pix_q;
  logic [AW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q <= pixel_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Line store memory: upper line in the high byte, middle line in the low.
  logic [2*PW-1:0] line_mem [MAX_WIDTH];
  logic [2*PW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_fire) begin
      line_mem[s1_col_q] <= {rd_q[PW-1:0], s1_pix_q};
    end
  end

  // Window of the two previous columns: top, middle, bottom each.
  logic [PW-1:0] win_q [6];

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= rd_q[2*PW-1:PW];
      win_q[4] <= rd_q[PW-1:0];
      win_q[5] <= s1_pix_q;
    end
  end

  // Result flags and positions of the pixel in stage one.
  logic          has_above;
  logic          col_last;
  logic [2:0]    new_mask;
  logic          has_res;
  logic [RW-1:0] rr;
  logic [AW-1:0] cc;
  logic          interior;

  always_comb begin
    has_above   = (s1_row_q != '0);
    col_last    = (s1_col_q == w_last_q);
    rr          = s1_row_q - RW'(1);
    cc          = s1_col_q - AW'(1);
    new_mask[0] = has_above & (s1_col_q != '0);
    new_mask[1] = has_above & col_last;
    new_mask[2] = (s1_row_q == h_last_q);
    has_res     = |new_mask;
    interior    = (rr != '0) & (rr != h_last_q) & (cc != '0) & (cc != w_last_q);
  end

  // Sobel kernel on the window, the line store outputs and the new pixel.
  logic signed [GW-1:0] t0, m0, b0, t1, b1, t2, m2, b2;
  logic signed [GW-1:0] grad_x, grad_y, grad;

  always_comb begin
    t0 = $signed(GW'(win_q[0]));
    m0 = $signed(GW'(win_q[1]));
    b0 = $signed(GW'(win_q[2]));
    t1 = $signed(GW'(win_q[3]));
    b1 = $signed(GW'(win_q[5]));
    t2 = $signed(GW'(rd_q[2*PW-1:PW]));
    m2 = $signed(GW'(rd_q[PW-1:0]));
    b2 = $signed(GW'(s1_pix_q));
    grad_x = (t2 - t0) + ((m2 - m0) <<< 1) + (b2 - b0);
    grad_y = (b0 - t0) + ((b1 - t1) <<< 1) + (b2 - t2);
    grad   = !interior ? '0 : (dir_q ? grad_x : grad_y);
  end

  // Result buffer: up to three pending results in fixed order.
  sobel_pkg::result_t res_q [3];
  logic [2:0]         mask_q;
  logic               buf_free;
  logic [1:0]         pick;
  logic [2:0]         pick_oh;

  assign buf_free   = (mask_q == 3'b000) |
                      (out_ready_i & ((mask_q & (mask_q - 3'd1)) == 3'b000));
  assign s1_fire    = s1_valid_q & (~has_res | buf_free);
  assign in_ready_o = ~s1_valid_q | s1_fire;
  assign load       = s1_fire & has_res;

  // The lowest pending slot goes out first.
  always_comb begin
    priority if (mask_q[0]) begin
      pick    = 2'd0;
      pick_oh = 3'b001;
    end else if (mask_q[1]) begin
      pick    = 2'd1;
      pick_oh = 3'b010;
    end else begin
      pick    = 2'd2;
      pick_oh = 3'b100;
    end
  end

  assign out_valid_o  = |mask_q;
  assign out_fire     = out_valid_o & out_ready_i;
  assign gradient_o   = res_q[pick].gradient;
  assign out_row_o    = res_q[pick].row;
  assign out_col_o    = res_q[pick].col;
  assign frame_last_o = res_q[pick].last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= 3'b000;
    end else if (load) begin
      mask_q <= new_mask;
    end else if (out_fire) begin
      mask_q <= mask_q & ~pick_oh;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q[0] <= '{gradient: grad, row: rr, col: CW'(cc), last: 1'b0};
      res_q[1] <= '{gradient: '0, row: rr, col: CW'(w_last_q), last: 1'b0};
      res_q[2] <= '{gradient: '0, row: h_last_q, col: CW'(s1_col_q),
                    last: col_last};
    end
  end

endmodule

@@ hdl/sobel_chk.sv @@
// ----------------------------------------------------------------------------
// Sobel 3x3 gradient checker
// Port-level assertions for the Sobel gradient block, bound to its top level.
// ----------------------------------------------------------------------------
`include "sobel_3x3_gradient_defines.svh"

module sobel_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic [sobel_pkg::PIX_W-1:0]         pixel_i,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [sobel_pkg::GRAD_W-1:0] gradient_o,
  input logic [sobel_pkg::ROW_W-1:0]         out_row_o,
  input logic [sobel_pkg::COL_W-1:0]         out_col_o,
  input logic                                frame_last_o,
  input logic                                psel,
  input logic                                penable,
  input logic                                pwrite,
  input logic [sobel_pkg::PADDR_W-1:0]       paddr,
  input logic [31:0]                         pwdata,
  input logic [31:0]                         prdata,
  input logic                                pready
);

  // A stalled result keeps its transaction.
  `SOBEL_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(gradient_o) && $stable(out_row_o) && $stable(out_col_o), "result changed while stalled")

  // The kernel never leaves its range.
  `SOBEL_ASSERT(a_grad_range, out_valid_o |-> (gradient_o <= 11'sd1020) && (gradient_o >= -11'sd1020), "gradient out of range")

  // Top row, left column and the frame's final result are border results.
  `SOBEL_ASSERT(a_border_zero, out_valid_o && (out_row_o == '0 || out_col_o == '0 || frame_last_o) |-> gradient_o == '0, "border result not zero")

  // No result is offered while in reset.
  `SOBEL_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "result offered during reset")

  // Register port never inserts wait states.
  `SOBEL_ASSERT_ALWAYS(a_pready, pready, "register port not ready")

endmodule

bind sobel_3x3_gradient sobel_chk u_sobel_chk (.*);
